// ===== rtl/tfc_pkg.sv =====
// Package for the text field cutter: sizes, register indexes, line-end code
// and the field selection helpers. No dependencies.
package tfc_pkg;

  localparam int LINE_STORE_DEPTH = 63;
  localparam int MAX_FIELDS = 64;

  localparam int ADDR_W = (LINE_STORE_DEPTH > 1) ? $clog2(LINE_STORE_DEPTH) : 1;
  localparam int CNT_W = $clog2(LINE_STORE_DEPTH + 1);
  localparam int FN_W = $clog2(MAX_FIELDS + 2);

  localparam logic [7:0] LINE_END = 8'd10;

  localparam logic [1:0] REG_INPUT_DELIMITER = 2'd0;
  localparam logic [1:0] REG_OUTPUT_DELIMITER = 2'd1;
  localparam logic [1:0] REG_FIELD_SELECT_MASK = 2'd2;

  // True when field k (numbered from 1) is selected by the mask.
  function automatic logic field_selected(input logic [FN_W-1:0] k, input logic [63:0] mask);
    logic [FN_W-1:0] km1;
    km1 = k - FN_W'(1);
    return (k >= FN_W'(1)) && (k <= FN_W'(MAX_FIELDS)) && mask[km1[5:0]];
  endfunction

  // True when any field below field k is selected.
  function automatic logic lower_selected(input logic [FN_W-1:0] k, input logic [63:0] mask);
    logic [63:0] below;
    logic [FN_W-1:0] km1;
    km1 = k - FN_W'(1);
    below = (64'd1 << km1) - 64'd1;
    return (k > FN_W'(1)) && ((mask & below) != 64'd0);
  endfunction

endpackage

// ===== rtl/tfc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/text_field_cutter.sv =====
// Text field cutter top level: splits lines into fields and passes the selected ones.
// Depends on tfc_pkg and tfc_ram.
//
// The block takes one byte per cycle whenever the output register is free and no replay
// is under way. A byte that is a delimiter or an ordinary character yields at most one
// output beat. A line end yields one beat, except when the first field is not selected
// and the line has had no delimiter: then the held start of the line (up to 63 bytes) is
// replayed from the line store before the line end, and the input stalls meanwhile, as
// the store is read one byte per cycle while the output is free, via its one read port.
// Each beat whose last_of_run is set closes the output caused by one input byte.
module text_field_cutter
  import tfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FLUSH = 3'b010,
    S_EOL   = 3'b100
  } state_t;

  state_t            state;
  logic [7:0]        input_delimiter;
  logic [7:0]        output_delimiter;
  logic [63:0]       field_select_mask;
  logic [FN_W-1:0]   field_number;
  logic [CNT_W-1:0]  store_count;
  logic [CNT_W-1:0]  flush_len;
  logic [ADDR_W-1:0] rd_ptr;

  logic              out_free;
  logic              out_load;
  logic              in_fire;
  logic              is_eol;
  logic              is_delim;
  logic              cur_sel;
  logic              field1_held;
  logic [FN_W-1:0]   field_number_next;
  logic              delim_emit;
  logic              flush_more;
  logic              store_we;
  logic              store_re;
  logic [ADDR_W-1:0] store_raddr;
  logic [7:0]        store_rdata;

  assign cfg_ready = 1'b1;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign in_fire = in_valid && in_ready;

  assign is_eol = (in_char == LINE_END);
  assign is_delim = !is_eol && (in_char == input_delimiter);
  assign cur_sel = field_selected(field_number, field_select_mask);
  assign field1_held = (field_number == FN_W'(1)) && !field_select_mask[0];
  assign field_number_next = (field_number <= FN_W'(MAX_FIELDS)) ?
                             field_number + FN_W'(1) : field_number;
  assign delim_emit = field_selected(field_number_next, field_select_mask) &&
                      lower_selected(field_number_next, field_select_mask);
  assign flush_more = (CNT_W'(rd_ptr) + CNT_W'(1)) < flush_len;

  assign out_load = (in_fire && (is_eol ? !(field1_held && (store_count != '0)) :
                                 (is_delim ? delim_emit : cur_sel))) ||
                    (((state == S_FLUSH) || (state == S_EOL)) && out_free);

  assign store_we = in_fire && !is_eol && !is_delim && field1_held &&
                    (store_count < CNT_W'(LINE_STORE_DEPTH));
  assign store_re = (in_fire && is_eol) || ((state == S_FLUSH) && out_free && flush_more);
  assign store_raddr = (state == S_FLUSH) ? rd_ptr + ADDR_W'(1) : '0;

  tfc_ram #(
    .WIDTH(8),
    .DEPTH(LINE_STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_count[ADDR_W-1:0]),
    .wdata (in_char),
    .re    (store_re),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      field_number <= FN_W'(1);
      store_count <= '0;
      input_delimiter <= 8'd9;
      output_delimiter <= 8'd9;
      field_select_mask <= 64'd1;
    end else begin
      out_valid <= out_load || (out_valid && !out_ready);

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_INPUT_DELIMITER: input_delimiter <= cfg_data[7:0];
          REG_OUTPUT_DELIMITER: output_delimiter <= cfg_data[7:0];
          REG_FIELD_SELECT_MASK: field_select_mask <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (is_eol) begin
              field_number <= FN_W'(1);
              store_count <= '0;
              if (field1_held && (store_count != '0)) begin
                state <= S_FLUSH;
                rd_ptr <= '0;
                flush_len <= store_count;
              end else begin
                out_char <= LINE_END;
                last_of_run <= 1'b1;
              end
            end else if (is_delim) begin
              field_number <= field_number_next;
              if (delim_emit) begin
                out_char <= output_delimiter;
                last_of_run <= 1'b1;
              end
            end else begin
              if (store_we) begin
                store_count <= store_count + CNT_W'(1);
              end
              if (cur_sel) begin
                out_char <= in_char;
                last_of_run <= 1'b1;
              end
            end
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            out_char <= store_rdata;
            last_of_run <= 1'b0;
            if (flush_more) begin
              rd_ptr <= rd_ptr + ADDR_W'(1);
            end else begin
              state <= S_EOL;
            end
          end
        end
        S_EOL: begin
          if (out_free) begin
            out_char <= LINE_END;
            last_of_run <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_store_count_range: assert property (@(posedge clk) disable iff (rst)
    store_count <= CNT_W'(LINE_STORE_DEPTH))
    else $error("line store count exceeds its depth");

  a_field_number_range: assert property (@(posedge clk) disable iff (rst)
    (field_number >= FN_W'(1)) && (field_number <= FN_W'(MAX_FIELDS + 1)))
    else $error("field number out of range");

  a_flush_in_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH) |-> (CNT_W'(rd_ptr) < flush_len))
    else $error("line store replay reads past the held bytes");

  a_eol_closes_run: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EOL) && out_free) |=>
      (out_valid && last_of_run && (out_char == LINE_END) && (state == S_IDLE)))
    else $error("replayed line not closed by a line end beat");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for text_field_cutter: byte stream in, cut fields out.
// Depends on tfc_pkg and the text_field_cutter RTL; predicts every output beat itself.
module tb_top;
  import tfc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 70;

  typedef struct packed {
    logic [7:0] ch;
    logic       closes_run;
  } out_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_char = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_char;
  logic        last_of_run;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_INPUT_DELIMITER;
  logic [63:0] cfg_data = 64'd0;

  logic [7:0]  in_delim = 8'd9;
  logic [7:0]  out_delim = 8'd9;
  logic [63:0] sel_mask = 64'd1;
  int          field_num = 1;
  logic [7:0]  held [LINE_STORE_DEPTH];
  int          held_cnt = 0;

  out_beat_t   pending_beats [$];
  out_beat_t   want;
  int          fail_count = 0;
  int          cycle_count = 0;
  int          items_sent = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  text_field_cutter uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_char(in_char),
    .out_valid(out_valid), .out_ready(out_ready), .out_char(out_char),
    .last_of_run(last_of_run),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready = rst ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected output beat: out_char %0d, last_of_run %0d", out_char, last_of_run);
        fail_count++;
      end else begin
        want = pending_beats.pop_front();
        if (out_char !== want.ch) begin
          $error("out_char mismatch: expected %0d, actual %0d", want.ch, out_char);
          fail_count++;
        end
        if (last_of_run !== want.closes_run) begin
          $error("last_of_run mismatch: expected %0d, actual %0d", want.closes_run, last_of_run);
          fail_count++;
        end
      end
    end
  end

  function automatic bit field_on(int k);
    return k >= 1 && k <= MAX_FIELDS && sel_mask[k-1];
  endfunction

  function automatic bit any_lower_on(int k);
    for (int j = 1; j < k && j <= MAX_FIELDS; j++) begin
      if (sel_mask[j-1]) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic predict_cut(input logic [7:0] c);
    out_beat_t run [$];
    if (c == LINE_END) begin
      if (field_num == 1 && !field_on(1)) begin
        for (int i = 0; i < held_cnt; i++) run.push_back('{held[i], 1'b0});
      end
      run.push_back('{LINE_END, 1'b0});
      field_num = 1;
      held_cnt = 0;
    end else if (c == in_delim) begin
      if (field_num <= MAX_FIELDS) field_num++;
      if (field_on(field_num) && any_lower_on(field_num)) run.push_back('{out_delim, 1'b0});
    end else begin
      if (field_num == 1 && !field_on(1) && held_cnt < LINE_STORE_DEPTH) begin
        held[held_cnt] = c;
        held_cnt++;
      end
      if (field_on(field_num)) run.push_back('{c, 1'b0});
    end
    if (run.size() > 0) run[run.size()-1].closes_run = 1'b1;
    foreach (run[i]) pending_beats.push_back(run[i]);
  endtask

  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_char = c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_cut(c);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_INPUT_DELIMITER: in_delim = val[7:0];
      REG_OUTPUT_DELIMITER: out_delim = val[7:0];
      REG_FIELD_SELECT_MASK: sel_mask = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_config(input logic [7:0] di, input logic [7:0] dout,
                             input logic [63:0] m);
    logic [63:0] noise;
    drain();
    noise = {$urandom(), $urandom()};
    write_reg(REG_INPUT_DELIMITER, {noise[63:8], di});
    noise = {$urandom(), $urandom()};
    write_reg(REG_OUTPUT_DELIMITER, {noise[63:8], dout});
    write_reg(REG_FIELD_SELECT_MASK, m);
  endtask

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == LINE_END || c == in_delim);
    return c;
  endfunction

  task automatic send_random_line();
    int kind;
    int nfields;
    int flen;
    kind = $urandom_range(99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 12)) send_char(8'($urandom_range(255)));
    end else begin
      if (kind < 11) nfields = $urandom_range(66, 70);
      else if (kind < 35) nfields = 1;
      else nfields = $urandom_range(2, 6);
      for (int f = 0; f < nfields; f++) begin
        if (f > 0) send_char(in_delim);
        if (kind < 11) flen = $urandom_range(0, 1);
        else if (kind < 16 && f == 0) flen = $urandom_range(60, 70);
        else flen = $urandom_range(0, 6);
        repeat (flen) send_char(text_char());
      end
      if ($urandom_range(9) != 0) send_char(LINE_END);
    end
  endtask

  task automatic apply_setting(input int s);
    logic [7:0]  di;
    logic [7:0]  dout;
    logic [63:0] m;
    di = 8'($urandom_range(255));
    dout = 8'($urandom_range(255));
    m = {$urandom(), $urandom()};
    case (s)
      0: begin di = 8'd9; dout = 8'd44; m = '1; end
      1: begin di = 8'd44; dout = 8'd0; m = 64'd0; end
      2: begin di = 8'd255; dout = 8'd255; m = 64'h8000_0000_0000_0002; end
      3: di = 8'd0;
      4: di = LINE_END;
      5: m[0] = 1'b0;
      6: m = m & 64'hFF;
      default: ;
    endcase
    load_config(di, dout, m);
  endtask

  task automatic test_reset_config();
    send_text("ab\tc\n");
    send_text("\tz\n");
  endtask

  task automatic test_directed_cases();
    load_config(8'd44, 8'd59, 64'h6);
    send_text("a,b,c,d\n");
    send_text("xy\n");
    load_config(LINE_END, 8'd255, 64'd0);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(LINE_END);
    send_char(LINE_END);
  endtask

  task automatic test_random_traffic();
    int send_pct [4] = '{0, 80, 0, 6};
    int recv_pct [4] = '{0, 0, 80, 6};
    int target;
    for (int p = 0; p < 4; p++) begin
      for (int h = 0; h < 2; h++) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        apply_setting(2 * p + h);
        send_idle_pct = send_pct[p];
        recv_stall_pct = recv_pct[p];
        target = items_sent + 38;
        while (items_sent < target) send_random_line();
      end
    end
  endtask

  task automatic test_sender_pause();
    send_idle_pct = 6;
    recv_stall_pct = 6;
    apply_setting(5);
    repeat (3) send_char(text_char());
    drain();
    send_char(in_delim);
    repeat (3) send_char(text_char());
    send_char(LINE_END);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_config();
    test_directed_cases();
    test_random_traffic();
    test_sender_pause();
    drain();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
